>>> src/pica_pkg.sv
// -----------------------------------------------------------------------------
// PI controller package
// Widths, limits, codes and shared types of the PI controller with
// integrator clamp.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pica_pkg;

   localparam int GAIN_W      = 21;
   localparam int ERR_W       = 16;
   localparam int PRESET_W    = 13;
   localparam int OUT_W       = 13;
   localparam int CSR_IDX_W   = 2;

   localparam int SCALE_SHIFT = 14;
   localparam int SCALE       = 1 << SCALE_SHIFT;
   localparam int MAX_ERROR   = 100;
   localparam int MAX_OUTPUT  = 5000;

   localparam int ERRC_W      = 8;
   localparam int PROD_W      = GAIN_W + ERRC_W;
   localparam int INTEG_W     = 28;
   localparam int SUM_W       = PROD_W + 1;

   localparam logic signed [ERR_W-1:0]   ERR_HI   = ERR_W'(MAX_ERROR);
   localparam logic signed [ERR_W-1:0]   ERR_LO   = -ERR_W'(MAX_ERROR);
   localparam logic signed [ERRC_W-1:0]  ERRC_HI  = ERRC_W'(MAX_ERROR);
   localparam logic signed [ERRC_W-1:0]  ERRC_LO  = -ERRC_W'(MAX_ERROR);
   localparam logic signed [SUM_W-1:0]   SUM_LIM  = SUM_W'(MAX_OUTPUT * SCALE);
   localparam logic signed [INTEG_W-1:0] INTEG_LIM = INTEG_W'(MAX_OUTPUT * SCALE);
   localparam logic [PRESET_W-1:0]       PRESET_MAX = PRESET_W'(MAX_OUTPUT);
   localparam logic [OUT_W-1:0]          OUT_MAX    = OUT_W'(MAX_OUTPUT);
   localparam int                        QUOT_W     = SUM_W - SCALE_SHIFT;
   localparam logic [QUOT_W-1:0]         QUOT_MAX   = QUOT_W'(MAX_OUTPUT);

   typedef enum logic {
      OP_STEP   = 1'b0,
      OP_PRESET = 1'b1
   } op_type;

   localparam logic [CSR_IDX_W-1:0] REG_P_GAIN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_I_GAIN = CSR_IDX_W'(1);

   typedef struct packed {
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] i_gain;
   } gains_type;

endpackage

>>> src/pica_if.sv
// -----------------------------------------------------------------------------
// PI controller channels
// Valid/ready channels for request words, response words and register writes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pica_req_if import pica_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              operation;
   logic [ERR_W-1:0]    error;
   logic [PRESET_W-1:0] preset_value;

   modport source (output valid, operation, error, preset_value, input ready);
   modport sink   (input valid, operation, error, preset_value, output ready);
endinterface

interface pica_rsp_if import pica_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] drive_value;

   modport source (output valid, drive_value, input ready);
   modport sink   (input valid, drive_value, output ready);
endinterface

interface pica_csr_if import pica_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [GAIN_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pica_csr.sv
// -----------------------------------------------------------------------------
// PI controller gain registers
// Holds the proportional and integral gains written through the register port.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pica_csr import pica_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pica_csr_if.sink   csr_ch,
   output gains_type  gains
);

   gains_type gains_ff;
   gains_type gains_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      gains_in = gains_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_P_GAIN: gains_in.p_gain = csr_ch.data;
            REG_I_GAIN: gains_in.i_gain = csr_ch.data;
            default:    gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

>>> src/pica_core.sv
// -----------------------------------------------------------------------------
// PI controller datapath
// Input register, integrator with clamp, output scaling and response register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pica_core import pica_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  gains_type  gains,
   pica_req_if.sink   req_ch,
   pica_rsp_if.source rsp_ch
);

   logic                      s1_valid_ff, s1_valid_in;
   op_type                    s1_op_ff;
   logic signed [ERRC_W-1:0]  s1_err_ff;
   logic [PRESET_W-1:0]       s1_preset_ff;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]          drive_ff;

   logic                      s1_advance;
   logic                      req_take;
   logic signed [ERRC_W-1:0]  err_clamped;
   logic [PRESET_W-1:0]       preset_clamped;
   logic signed [PROD_W-1:0]  p_term;
   logic signed [PROD_W-1:0]  i_term;
   logic signed [SUM_W-1:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_step;
   logic signed [INTEG_W-1:0] integ_preset;
   logic signed [SUM_W-1:0]   out_sum;
   logic [QUOT_W-1:0]         quot;
   logic [OUT_W-1:0]          drive_next;

   assign s1_advance   = s1_valid_ff &&
                         (s1_op_ff == OP_PRESET || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);

   always_comb begin
      if ($signed(req_ch.error) > ERR_HI) begin
         err_clamped = ERRC_HI;
      end else if ($signed(req_ch.error) < ERR_LO) begin
         err_clamped = ERRC_LO;
      end else begin
         err_clamped = req_ch.error[ERRC_W-1:0];
      end
      if (req_ch.preset_value > PRESET_MAX) begin
         preset_clamped = PRESET_MAX;
      end else begin
         preset_clamped = req_ch.preset_value;
      end
   end

   always_comb begin
      p_term       = PROD_W'($signed(gains.p_gain)) * PROD_W'(s1_err_ff);
      i_term       = PROD_W'($signed(gains.i_gain)) * PROD_W'(s1_err_ff);
      integ_sum    = SUM_W'(integ_ff) + SUM_W'(i_term);
      integ_preset = INTEG_W'(s1_preset_ff) << SCALE_SHIFT;
      if (integ_sum > SUM_LIM) begin
         integ_step = INTEG_LIM;
      end else if (integ_sum < -SUM_LIM) begin
         integ_step = -INTEG_LIM;
      end else begin
         integ_step = integ_sum[INTEG_W-1:0];
      end
      out_sum = SUM_W'(p_term) + SUM_W'(integ_step);
      quot    = out_sum[SUM_W-1:SCALE_SHIFT];
      if (out_sum < 0) begin
         drive_next = '0;
      end else if (quot > QUOT_MAX) begin
         drive_next = OUT_MAX;
      end else begin
         drive_next = quot[OUT_W-1:0];
      end
      integ_in = integ_ff;
      if (s1_advance) begin
         if (s1_op_ff == OP_PRESET) begin
            integ_in = integ_preset;
         end else begin
            integ_in = integ_step;
         end
      end
      if (s1_advance && s1_op_ff == OP_STEP) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
      end
      if (req_take) begin
         s1_op_ff     <= req_ch.operation;
         s1_err_ff    <= err_clamped;
         s1_preset_ff <= preset_clamped;
      end
      if (s1_advance && s1_op_ff == OP_STEP) begin
         drive_ff <= drive_next;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.drive_value = drive_ff;

   integ_in_range: assert property (@(posedge clock) disable iff (reset)
      integ_ff <= INTEG_LIM && integ_ff >= -INTEG_LIM)
      else $error("Integrator outside its clamp range.");

   drive_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> drive_ff <= OUT_MAX)
      else $error("Drive value above the output limit.");

   preset_loads: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_op_ff == OP_PRESET) |=> integ_ff == $past(integ_preset))
      else $error("Preset word did not load the integrator.");

   stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s1_op_ff == OP_STEP && rsp_valid_ff))
      else $error("Request side stalled without a blocked step word.");

endmodule

>>> src/pi_controller_antiwindup.sv
// -----------------------------------------------------------------------------
// PI controller with integrator clamp
// Fixed-point PI controller whose integrator saturates at the output range.
// -----------------------------------------------------------------------------
// The block takes one request word per clock cycle unless a step word is held
// by a stalled response. A step word is captured with its error clamped into
// the input register; the gains, integrator update, scaling and output clamp
// are then worked out combinationally into the response register, from which
// it is presented, at one word per cycle. A preset word loads the integrator
// and produces no response. The user must write gains through the register
// port while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module pi_controller_antiwindup import pica_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pica_req_if.sink   req_ch,
   pica_rsp_if.source rsp_ch,
   pica_csr_if.sink   csr_ch
);

   gains_type gains;

   pica_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .gains  (gains)
   );

   pica_core u_core (
      .clock  (clock),
      .reset  (reset),
      .gains  (gains),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
